// ===== hdl/sm4_pkg.sv =====
// SM4 shared definitions: S-box, FK and CK constants, the tau and linear
// transforms, the encryption round, the key schedule step and register indexes.
// No dependencies.
package sm4_pkg;

   localparam int WORD_W    = 32;
   localparam int BLOCK_W   = 128;
   localparam int HALF_W    = 64;
   localparam int CSR_IDX_W = 8;
   localparam int CK_IDX_W  = 5;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LOW  = 8'd1;

   // System parameter FK, words 0 to 3 from the top
   localparam logic [BLOCK_W-1:0] FK_ALL = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

   localparam logic [7:0] SBOX_TABLE [0:255] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // Byte-wise S-box substitution
   function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] v);
      return {SBOX_TABLE[v[31:24]], SBOX_TABLE[v[23:16]],
              SBOX_TABLE[v[15:8]],  SBOX_TABLE[v[7:0]]};
   endfunction

   // Linear transform L of the data path
   function automatic logic [WORD_W-1:0] l_enc(input logic [WORD_W-1:0] b);
      return b ^ ((b << 2) | (b >> 30)) ^ ((b << 10) | (b >> 22))
               ^ ((b << 18) | (b >> 14)) ^ ((b << 24) | (b >> 8));
   endfunction

   // Linear transform L' of the key schedule
   function automatic logic [WORD_W-1:0] l_key(input logic [WORD_W-1:0] b);
      return b ^ ((b << 13) | (b >> 19)) ^ ((b << 23) | (b >> 9));
   endfunction

   // CK word i: byte j is (4i + j) * 7 mod 256
   function automatic logic [WORD_W-1:0] ck_word(input logic [CK_IDX_W-1:0] idx);
      logic [7:0]        base;
      logic [WORD_W-1:0] w;
      base = {1'b0, idx, 2'b00};
      w    = '0;
      for (int j = 0; j < 4; j++) begin
         w[31-8*j -: 8] = 8'((base + 8'(j)) * 8'd7);
      end
      return w;
   endfunction

   // One round over the word window {w0, w1, w2, w3}; shift in the new word
   function automatic logic [BLOCK_W-1:0] enc_round(input logic [BLOCK_W-1:0] s,
                                                    input logic [WORD_W-1:0]  rk);
      logic [WORD_W-1:0] t;
      t = s[95:64] ^ s[63:32] ^ s[31:0] ^ rk;
      return {s[95:0], s[127:96] ^ l_enc(tau(t))};
   endfunction

   // One key schedule step; same window shape as the data round
   function automatic logic [BLOCK_W-1:0] key_round(input logic [BLOCK_W-1:0] s,
                                                    input logic [WORD_W-1:0]  ck);
      logic [WORD_W-1:0] t;
      t = s[95:64] ^ s[63:32] ^ s[31:0] ^ ck;
      return {s[95:0], s[127:96] ^ l_key(tau(t))};
   endfunction

endpackage

// ===== hdl/sm4_if.sv =====
// Valid/ready channel interfaces for the SM4 block: plaintext request,
// ciphertext response and configuration write. Uses sm4_pkg for widths.
interface sm4_req_if;
   logic                        valid;
   logic                        ready;
   logic [sm4_pkg::HALF_W-1:0]  plain_high;
   logic [sm4_pkg::HALF_W-1:0]  plain_low;
   modport source (output valid, plain_high, plain_low, input ready);
   modport sink   (input valid, plain_high, plain_low, output ready);
endinterface

interface sm4_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sm4_pkg::HALF_W-1:0]  cipher_high;
   logic [sm4_pkg::HALF_W-1:0]  cipher_low;
   modport source (output valid, cipher_high, cipher_low, input ready);
   modport sink   (input valid, cipher_high, cipher_low, output ready);
endinterface

interface sm4_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sm4_pkg::CSR_IDX_W-1:0] index;
   logic [sm4_pkg::HALF_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/sm4_block_encrypt.sv =====
// SM4 block encryption, top level: fully unrolled round pipeline with an
// output skid stage. Depends on sm4_pkg, sm4_if.sv and sm4_key_sched.
//
// Usage:
//  - csr_port writes the key: index 0 is key_high, index 1 is key_low. Any
//    write to either re-expands the round keys, one key round per cycle;
//    req_port.ready stays low until that is done. Unknown indexes are
//    accepted and ignored. Write keys only while idle.
//  - req_port carries one 128-bit plaintext word, big-endian.
//  - rsp_port returns one ciphertext word per request, in request order.
//  - Throughput: one word per cycle while no key expansion runs and the
//    skid stage is empty; each round is one pipeline stage of S-box
//    lookups and the L transform, so ROUNDS stages in a row.
//  - Path: the request edge loads the first round stage; the word walks
//    the round stages in order and leaves the last into the output register.
//  - Reset clears the pipeline and loads the all-zero key; req_port.ready
//    stays low until its expansion is done.
//  - Receiver stall: the output register holds its word and one more word
//    drops into the skid stage; then the whole pipeline holds and
//    req_port.ready falls. Nothing is lost or repeated.
module sm4_block_encrypt #(
   parameter int ROUNDS = 32
) (
   input  logic      clock,
   input  logic      reset,
   sm4_req_if.sink   req_port,
   sm4_rsp_if.source rsp_port,
   sm4_csr_if.sink   csr_port
);

   logic [ROUNDS-1:0][sm4_pkg::WORD_W-1:0] round_key;
   logic                                   key_busy;

   logic [ROUNDS-1:0]            stage_valid_ff;
   logic [ROUNDS-1:0]            stage_valid_in;
   logic [sm4_pkg::BLOCK_W-1:0]  stage_data_ff [ROUNDS];
   logic [sm4_pkg::BLOCK_W-1:0]  stage_data_in [ROUNDS];

   logic                         out_valid_ff;
   logic [sm4_pkg::BLOCK_W-1:0]  out_data_ff;
   logic                         skid_valid_ff;
   logic [sm4_pkg::BLOCK_W-1:0]  skid_data_ff;
   logic [sm4_pkg::BLOCK_W-1:0]  result_word;

   logic advance;
   logic in_accept;
   logic push;
   logic pop;

   sm4_key_sched #(
      .ROUNDS (ROUNDS)
   ) u_key_sched (
      .clock     (clock),
      .reset     (reset),
      .csr_port  (csr_port),
      .key_busy  (key_busy),
      .round_key (round_key)
   );

   // Pipeline moves whenever the skid stage is free
   assign advance        = !skid_valid_ff;
   assign req_port.ready = advance && !key_busy;
   assign in_accept      = req_port.valid && req_port.ready;

   // One round per stage
   always_comb begin
      stage_valid_in   = {stage_valid_ff[ROUNDS-2:0], in_accept};
      stage_data_in[0] = sm4_pkg::enc_round({req_port.plain_high, req_port.plain_low},
                                            round_key[0]);
      for (int i = 1; i < ROUNDS; i++) begin
         stage_data_in[i] = sm4_pkg::enc_round(stage_data_ff[i-1], round_key[i]);
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else if (advance) begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Advance round data
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < ROUNDS; i++) begin
            stage_data_ff[i] <= stage_data_in[i];
         end
      end
   end

   // Final word order is X35, X34, X33, X32
   assign result_word = {stage_data_ff[ROUNDS-1][31:0],  stage_data_ff[ROUNDS-1][63:32],
                         stage_data_ff[ROUNDS-1][95:64], stage_data_ff[ROUNDS-1][127:96]};

   assign push = advance && stage_valid_ff[ROUNDS-1];
   assign pop  = out_valid_ff && rsp_port.ready;

   // Output register and skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_ff  <= result_word;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= result_word;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.cipher_high = out_data_ff[127:64];
   assign rsp_port.cipher_low  = out_data_ff[63:0];

`ifndef SYNTHESIS
   // No request enters while round keys are being rebuilt
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      in_accept |-> !key_busy)
      else $error("request accepted during key expansion");

   // Skid stage fills only behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage valid with empty output register");

   // A word leaving the last round always lands in the output side
   a_last_stage_kept: assert property (@(posedge clock) disable iff (reset)
      push |=> out_valid_ff)
      else $error("result word dropped at pipeline exit");

   // A full skid stage freezes the pipeline
   a_hold_on_skid: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(stage_valid_ff))
      else $error("pipeline moved while skid stage full");
`endif

endmodule

// ===== hdl/sm4_key_sched.sv =====
// SM4 key registers and round key schedule: one key round per cycle after
// reset or any key write. Depends on sm4_pkg and sm4_csr_if.
module sm4_key_sched #(
   parameter int ROUNDS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   sm4_csr_if.sink                               csr_port,
   output logic                                  key_busy,
   output logic [ROUNDS-1:0][sm4_pkg::WORD_W-1:0] round_key
);

   localparam int CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   typedef enum logic [1:0] {
      KS_IDLE,
      KS_LOAD,
      KS_RUN
   } ks_state_type;

   ks_state_type                          state_ff;
   logic [sm4_pkg::HALF_W-1:0]            key_high_ff;
   logic [sm4_pkg::HALF_W-1:0]            key_low_ff;
   logic [sm4_pkg::BLOCK_W-1:0]           kwin_ff;
   logic [CNT_W-1:0]                      kcnt_ff;
   logic [ROUNDS-1:0][sm4_pkg::WORD_W-1:0] round_key_ff;
   logic [sm4_pkg::BLOCK_W-1:0]           kwin_in;
   logic                                  wr_fire;
   logic                                  key_wr;

   // Writes are always taken; a key write during expansion restarts it
   assign csr_port.ready = 1'b1;
   assign wr_fire        = csr_port.valid && csr_port.ready;
   assign key_wr         = wr_fire && (csr_port.index inside
                              {sm4_pkg::REG_KEY_HIGH, sm4_pkg::REG_KEY_LOW});
   assign key_busy       = (state_ff != KS_IDLE);
   assign round_key      = round_key_ff;

   // Next key window: one schedule step
   assign kwin_in = sm4_pkg::key_round(kwin_ff,
                       sm4_pkg::ck_word(sm4_pkg::CK_IDX_W'(kcnt_ff)));

   // Sequence the expansion and hold the key halves
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= KS_LOAD;
         key_high_ff <= '0;
         key_low_ff  <= '0;
         kcnt_ff     <= '0;
      end else begin
         // Latch a key word; an unknown index changes nothing
         if (wr_fire) begin
            case (csr_port.index)
               sm4_pkg::REG_KEY_HIGH: begin
                  key_high_ff <= csr_port.data;
               end
               sm4_pkg::REG_KEY_LOW: begin
                  key_low_ff <= csr_port.data;
               end
               default: begin
               end
            endcase
         end
         // Restart on a key write, else step the expansion
         if (key_wr) begin
            state_ff <= KS_LOAD;
         end else begin
            case (state_ff)
               KS_LOAD: begin
                  kwin_ff  <= {key_high_ff, key_low_ff} ^ sm4_pkg::FK_ALL;
                  kcnt_ff  <= '0;
                  state_ff <= KS_RUN;
               end
               KS_RUN: begin
                  round_key_ff[kcnt_ff] <= kwin_in[31:0];
                  kwin_ff               <= kwin_in;
                  kcnt_ff               <= kcnt_ff + 1'b1;
                  if (kcnt_ff == CNT_W'(ROUNDS - 1)) begin
                     state_ff <= KS_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

// ===== tb/sv/sm4_block_encrypt_tb.sv =====
// Self-checking testbench for sm4_block_encrypt: directed and random plaintext
// words under several keys, each compared with an SM4 model or a known ciphertext.
// Depends on sm4_pkg, the channel interfaces in sm4_if.sv and the block itself.
module sm4_block_encrypt_tb;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 11;
   localparam int ROUNDS       = 32;
   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_WORDS   = 50;

   // Indexes outside the register map; writes there must be dropped
   localparam logic [sm4_pkg::CSR_IDX_W-1:0] REG_UNMAPPED_TOP = 8'hff;
   localparam logic [sm4_pkg::CSR_IDX_W-1:0] REG_UNMAPPED_LOW = 8'h02;

   localparam logic [sm4_pkg::HALF_W-1:0] ALL_ONES = {sm4_pkg::HALF_W{1'b1}};

   localparam logic [7:0] SUBST_BOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   localparam logic [31:0] FK_WORDS [4] = '{
      32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
   };

   localparam logic [31:0] CK_WORDS [32] = '{
      32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269,
      32'h70777e85, 32'h8c939aa1, 32'ha8afb6bd, 32'hc4cbd2d9,
      32'he0e7eef5, 32'hfc030a11, 32'h181f262d, 32'h343b4249,
      32'h50575e65, 32'h6c737a81, 32'h888f969d, 32'ha4abb2b9,
      32'hc0c7ced5, 32'hdce3eaf1, 32'hf8ff060d, 32'h141b2229,
      32'h30373e45, 32'h4c535a61, 32'h686f767d, 32'h848b9299,
      32'ha0a7aeb5, 32'hbcc3cad1, 32'hd8dfe6ed, 32'hf4fb0209,
      32'h10171e25, 32'h2c333a41, 32'h484f565d, 32'h646b7279
   };

   typedef struct packed {
      logic [sm4_pkg::HALF_W-1:0] cipher_high;
      logic [sm4_pkg::HALF_W-1:0] cipher_low;
   } cipher_type;

   typedef enum logic {ROW_KEY, ROW_BLOCK} row_kind_type;

   // One directed step: a key register write or a plaintext word
   typedef struct {
      row_kind_type                  kind;
      logic [sm4_pkg::CSR_IDX_W-1:0] index;
      logic [sm4_pkg::HALF_W-1:0]    high;
      logic [sm4_pkg::HALF_W-1:0]    low;
      bit                            known;
      cipher_type                    known_cipher;
   } step_row_type;

   logic clock;
   logic reset;

   sm4_req_if req_bus ();
   sm4_rsp_if rsp_bus ();
   sm4_csr_if csr_bus ();

   sm4_block_encrypt #(.ROUNDS(ROUNDS)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // Encryption model state
   logic [sm4_pkg::HALF_W-1:0] key_high_q;
   logic [sm4_pkg::HALF_W-1:0] key_low_q;
   logic [31:0]                key_words [ROUNDS];

   cipher_type   pending_cipher [$];
   step_row_type directed_rows [$];
   int           mismatches = 0;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [31:0] substitute(input logic [31:0] v);
      logic [31:0] r;
      for (int b = 0; b < 4; b++) begin
         r[8*b +: 8] = SUBST_BOX[v[8*b +: 8]];
      end
      return r;
   endfunction

   function automatic logic [31:0] data_mix(input logic [31:0] v);
      logic [31:0] s;
      s = substitute(v);
      return s ^ rotl32(s, 2) ^ rotl32(s, 10) ^ rotl32(s, 18) ^ rotl32(s, 24);
   endfunction

   function automatic logic [31:0] key_mix(input logic [31:0] v);
      logic [31:0] s;
      s = substitute(v);
      return s ^ rotl32(s, 13) ^ rotl32(s, 23);
   endfunction

   // Rebuild all round keys from the two key halves as they stand
   function automatic void expand_key_words();
      logic [31:0] w [4];
      logic [31:0] nk;
      w[0] = key_high_q[63:32] ^ FK_WORDS[0];
      w[1] = key_high_q[31:0]  ^ FK_WORDS[1];
      w[2] = key_low_q[63:32]  ^ FK_WORDS[2];
      w[3] = key_low_q[31:0]   ^ FK_WORDS[3];
      for (int r = 0; r < ROUNDS; r++) begin
         nk = w[0] ^ key_mix(w[1] ^ w[2] ^ w[3] ^ CK_WORDS[r]);
         w[0] = w[1];
         w[1] = w[2];
         w[2] = w[3];
         w[3] = nk;
         key_words[r] = nk;
      end
   endfunction

   // Run the 32 rounds; output words come out reversed
   function automatic cipher_type encrypt_block(input logic [sm4_pkg::HALF_W-1:0] ph,
                                                input logic [sm4_pkg::HALF_W-1:0] pl);
      logic [31:0] w [4];
      logic [31:0] nw;
      cipher_type  c;
      w[0] = ph[63:32];
      w[1] = ph[31:0];
      w[2] = pl[63:32];
      w[3] = pl[31:0];
      for (int r = 0; r < ROUNDS; r++) begin
         nw = w[0] ^ data_mix(w[1] ^ w[2] ^ w[3] ^ key_words[r]);
         w[0] = w[1];
         w[1] = w[2];
         w[2] = w[3];
         w[3] = nw;
      end
      c.cipher_high = {w[3], w[2]};
      c.cipher_low  = {w[1], w[0]};
      return c;
   endfunction

   // Append one directed step to the table
   function automatic void add_row(input row_kind_type kind,
                                   input logic [sm4_pkg::CSR_IDX_W-1:0] index,
                                   input logic [sm4_pkg::HALF_W-1:0] high,
                                   input logic [sm4_pkg::HALF_W-1:0] low,
                                   input bit known,
                                   input cipher_type known_cipher);
      step_row_type row;
      row.kind         = kind;
      row.index        = index;
      row.high         = high;
      row.low          = low;
      row.known        = known;
      row.known_cipher = known_cipher;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Plaintext halves: random half the time, else all zeros, all ones, one bit set or one bit clear
   function automatic logic [sm4_pkg::HALF_W-1:0] rand_half();
      logic [sm4_pkg::HALF_W-1:0] bit_one;
      bit_one = 64'd1 << $urandom_range(0, sm4_pkg::HALF_W - 1);
      case ($urandom_range(0, 7))
         0: rand_half = '0;
         1: rand_half = ALL_ONES;
         2: rand_half = bit_one;
         3: rand_half = ~bit_one;
         default: rand_half = {$urandom, $urandom};
      endcase
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Limit on the whole run
   initial begin
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("CHECK FAILED");
      $finish;
   end

   // Response ready: rotate among stall styles every so often
   initial begin : rsp_stall
      int cycle;
      int stall_mode;
      int hold;
      cycle = 0;
      stall_mode = 0;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (cycle % 120 == 0) begin
            stall_mode = $urandom_range(0, 3);
         end
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2: begin
               if (hold > 0) begin
                  hold--;
                  rsp_bus.ready <= 1'b0;
               end else if ($urandom_range(0, 7) == 0) begin
                  hold = $urandom_range(1, 20);
                  rsp_bus.ready <= 1'b0;
               end else begin
                  rsp_bus.ready <= 1'b1;
               end
            end
            default: rsp_bus.ready <= ((cycle / 4) % 2 == 0);
         endcase
      end
   end

   // Compare each accepted ciphertext word with the oldest expectation
   always @(posedge clock) begin : rsp_check
      cipher_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_cipher.size() == 0) begin
            $error("unexpected ciphertext word %h_%h",
                   rsp_bus.cipher_high, rsp_bus.cipher_low);
            mismatches++;
         end else begin
            want = pending_cipher.pop_front();
            if (rsp_bus.cipher_high !== want.cipher_high) begin
               $error("cipher_high: expected %h, actual %h",
                      want.cipher_high, rsp_bus.cipher_high);
               mismatches++;
            end
            if (rsp_bus.cipher_low !== want.cipher_low) begin
               $error("cipher_low: expected %h, actual %h",
                      want.cipher_low, rsp_bus.cipher_low);
               mismatches++;
            end
         end
      end
   end

   // Present one plaintext word and hold it until taken; valid stays high
   task automatic offer_block(input logic [sm4_pkg::HALF_W-1:0] ph,
                              input logic [sm4_pkg::HALF_W-1:0] pl,
                              input bit known, input cipher_type known_cipher);
      req_bus.valid      <= 1'b1;
      req_bus.plain_high <= ph;
      req_bus.plain_low  <= pl;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      if (known) begin
         pending_cipher.insert(pending_cipher.size(), known_cipher);
      end else begin
         pending_cipher.insert(pending_cipher.size(), encrypt_block(ph, pl));
      end
   endtask

   // Wait until every outstanding ciphertext word has come back
   task automatic wait_drained();
      while (pending_cipher.size() != 0) @(posedge clock);
   endtask

   // Write one register; valid stays high for the caller to drop
   task automatic write_csr(input logic [sm4_pkg::CSR_IDX_W-1:0] index,
                            input logic [sm4_pkg::HALF_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      if (index == sm4_pkg::REG_KEY_HIGH) begin
         key_high_q = value;
         expand_key_words();
      end else if (index == sm4_pkg::REG_KEY_LOW) begin
         key_low_q = value;
         expand_key_words();
      end
   endtask

   // Random plaintext words in bursts with random gaps
   task automatic run_blocks(input int count);
      int burst;
      int gap;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && sent < count) begin
            offer_block(rand_half(), rand_half(), 1'b0, '0);
            burst--;
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin : stimulus
      step_row_type               row;
      logic [sm4_pkg::HALF_W-1:0] new_high;
      logic [sm4_pkg::HALF_W-1:0] new_low;
      int                         order;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.plain_high <= '0;
      req_bus.plain_low  <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= '0;
      csr_bus.data       <= '0;
      key_high_q = '0;
      key_low_q  = '0;
      expand_key_words();

      // Directed steps; the standard test vector is typed in
      add_row(ROW_BLOCK, '0, '0, '0, 0, '0);
      add_row(ROW_BLOCK, '0, ALL_ONES, ALL_ONES, 0, '0);
      add_row(ROW_BLOCK, '0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 0, '0);
      add_row(ROW_BLOCK, '0, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 0, '0);
      add_row(ROW_BLOCK, '0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 0, '0);
      // Unmapped index: keys must not move
      add_row(ROW_KEY, REG_UNMAPPED_TOP, ALL_ONES, '0, 0, '0);
      add_row(ROW_BLOCK, '0, '0, '0, 0, '0);
      // Half-written key takes effect at once
      add_row(ROW_KEY, sm4_pkg::REG_KEY_HIGH, 64'h0123_4567_89ab_cdef, '0, 0, '0);
      add_row(ROW_BLOCK, '0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 0, '0);
      add_row(ROW_KEY, sm4_pkg::REG_KEY_LOW, 64'hfedc_ba98_7654_3210, '0, 0, '0);
      add_row(ROW_BLOCK, '0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1,
              {64'h681e_df34_d206_965e, 64'h86b3_e94f_536e_4246});
      add_row(ROW_BLOCK, '0, '0, '0, 0, '0);
      add_row(ROW_BLOCK, '0, ALL_ONES, ALL_ONES, 0, '0);
      // Extreme key
      add_row(ROW_KEY, sm4_pkg::REG_KEY_HIGH, ALL_ONES, '0, 0, '0);
      add_row(ROW_KEY, sm4_pkg::REG_KEY_LOW, ALL_ONES, '0, 0, '0);
      add_row(ROW_BLOCK, '0, '0, '0, 0, '0);
      add_row(ROW_BLOCK, '0, ALL_ONES, ALL_ONES, 0, '0);
      add_row(ROW_BLOCK, '0, '0, 64'h1, 0, '0);
      add_row(ROW_KEY, sm4_pkg::REG_KEY_LOW, '0, '0, 0, '0);
      add_row(ROW_BLOCK, '0, ALL_ONES, '0, 0, '0);
      add_row(ROW_BLOCK, '0, '0, ALL_ONES, 0, '0);
      add_row(ROW_KEY, REG_UNMAPPED_LOW, '0, '0, 0, '0);
      add_row(ROW_BLOCK, '0, 64'hdead_beef_0bad_f00d, 64'h1357_9bdf_2468_ace0, 0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; key writes only once the pipe is empty
      for (int i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_KEY) begin
            req_bus.valid <= 1'b0;
            wait_drained();
            write_csr(row.index, row.high);
            if (i + 1 == directed_rows.size() || directed_rows[i + 1].kind != ROW_KEY) begin
               csr_bus.valid <= 1'b0;
            end
         end else begin
            offer_block(row.high, row.low, row.known, row.known_cipher);
         end
      end

      // Random phases, each under a new key
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         req_bus.valid <= 1'b0;
         wait_drained();
         case (phase)
            0: begin new_high = ALL_ONES; new_low = ALL_ONES; end
            1: begin new_high = '0;       new_low = '0;       end
            2: begin new_high = ALL_ONES; new_low = '0;       end
            3: begin new_high = '0;       new_low = ALL_ONES; end
            default: begin
               new_high = {$urandom, $urandom};
               new_low  = {$urandom, $urandom};
            end
         endcase
         order = $urandom_range(0, 3);
         if ($urandom_range(0, 1) == 1) begin
            write_csr(sm4_pkg::CSR_IDX_W'($urandom_range(2, 255)), {$urandom, $urandom});
         end
         // Sometimes touch only one half of the key
         if (order != 3 || phase < 5) begin
            write_csr(sm4_pkg::REG_KEY_HIGH, new_high);
         end
         if (order != 2 || phase < 5) begin
            write_csr(sm4_pkg::REG_KEY_LOW, new_low);
         end
         csr_bus.valid <= 1'b0;

         if (phase == 4) begin
            // Pause mid-phase until the pipe is empty
            run_blocks(PHASE_WORDS / 2);
            req_bus.valid <= 1'b0;
            wait_drained();
            run_blocks(PHASE_WORDS - PHASE_WORDS / 2);
         end else begin
            run_blocks(PHASE_WORDS);
         end
      end

      // Drain and allow stray words to show up
      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (ROUNDS + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/sm4_pkg.sv
hdl/sm4_if.sv
hdl/sm4_key_sched.sv
hdl/sm4_block_encrypt.sv
tb/sv/sm4_block_encrypt_tb.sv
